@@ hdl/chp_pkg.sv @@
package chp_pkg;

    // Width of the perimeter result and its saturation value.
    localparam int PERIM_W = 34;
    localparam logic [PERIM_W-1:0] PERIM_MAX = '1;

    // Operations of the shared multiply-accumulate unit.
    typedef enum logic [1:0] {
        MAC_CROSS = 2'd0,   // ax*by - bx*ay
        MAC_DA    = 2'd1,   // ax*ax + ay*ay
        MAC_DB    = 2'd2    // bx*bx + by*by
    } t_mac_op;

    // Sequencer states.
    typedef enum logic [24:0] {
        ST_LOAD       = 25'h0000001,
        ST_SORT_NEXT  = 25'h0000002,
        ST_SORT_KWAIT = 25'h0000004,
        ST_SORT_RD    = 25'h0000008,
        ST_SORT_BWAIT = 25'h0000010,
        ST_SORT_CHK   = 25'h0000020,
        ST_SORT_DA    = 25'h0000040,
        ST_SORT_DB    = 25'h0000080,
        ST_MAC        = 25'h0000100,
        ST_SCAN_INIT  = 25'h0000200,
        ST_SCAN_P0    = 25'h0000400,
        ST_SCAN_P1    = 25'h0000800,
        ST_SCAN_NEXT  = 25'h0001000,
        ST_SCAN_IWAIT = 25'h0002000,
        ST_SCAN_TEST  = 25'h0004000,
        ST_SCAN_CHK   = 25'h0008000,
        ST_SCAN_SWAIT = 25'h0010000,
        ST_SCAN_SPT   = 25'h0020000,
        ST_PER_INIT   = 25'h0040000,
        ST_PER_SRD    = 25'h0080000,
        ST_PER_PT     = 25'h0100000,
        ST_PER_SQ     = 25'h0200000,
        ST_ROOT       = 25'h0400000,
        ST_PER_ADD    = 25'h0800000,
        ST_DONE       = 25'h1000000
    } t_state;

endpackage

@@ hdl/convex_hull_perimeter.sv @@
// Channel   Direction  Handshake         Payload
// input     in         i_valid/o_stall   i_px, i_py, i_is_last
// output    out        o_valid/i_stall   o_perimeter, o_hull_size, o_overflowed
//
// Points load at one per cycle while o_stall is low. The point marked last starts the
// hull work, which runs on one shared multiplier and one digit-serial square root
// unit: an insertion sort around the pivot, a Graham scan that pops on each non-left
// turn, and a walk over the hull edges that takes a square root per edge.
// Reset is synchronous and active low; no memory is cleared.
// The input stalls from the last point until the result is registered; a held result
// waits in the output register and does not stop the next set loading.
module convex_hull_perimeter
    import chp_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COORD_BITS-1:0]        i_px,
    input  logic signed [COORD_BITS-1:0]        i_py,
    input  logic                                i_is_last,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [PERIM_W-1:0]                  o_perimeter,
    output logic [$clog2(MAX_POINTS+1)-1:0]     o_hull_size,
    output logic                                o_overflowed
);

    localparam int C     = COORD_BITS;
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int W     = 2 * C + 4;
    localparam int RW    = 32 + FRAC_BITS;
    localparam int REM_W = RW + 2;
    localparam int SQV_W = 64 + 2 * FRAC_BITS;
    localparam int SCW   = $clog2(RW);
    localparam int SUMW  = ((RW > PERIM_W) ? RW : PERIM_W) + 1;

    function automatic logic signed [C:0] f_sub(input logic signed [C-1:0] a,
                                                 input logic signed [C-1:0] b);
        return {a[C-1], a} - {b[C-1], b};
    endfunction

    // Sequencer and counters.
    t_state r_state, n_state, r_ret, n_ret;
    t_mac_op r_op, n_op;
    logic [1:0] r_ph, n_ph;
    logic [CW-1:0] r_cnt, n_cnt, r_i, n_i, r_j, n_j, r_top, n_top, r_k, n_k;
    logic r_ovf, n_ovf, r_close, n_close, r_ovalid, n_ovalid;
    logic [SCW-1:0] r_sc, n_sc;

    // Datapath registers.
    logic signed [C-1:0] r_pvx, n_pvx, r_pvy, n_pvy;
    logic signed [C-1:0] r_kx, n_kx, r_ky, n_ky, r_wx, n_wx, r_wy, n_wy;
    logic signed [C-1:0] r_tx, n_tx, r_ty, n_ty, r_sx, n_sx, r_sy, n_sy;
    logic signed [C:0] r_ax, n_ax, r_ay, n_ay, r_bx, n_bx, r_by, n_by;
    logic signed [2*C+1:0] r_prod, mul;
    logic signed [W-1:0] r_acc, n_acc, r_da, n_da;
    logic [SQV_W-1:0] r_sqv, n_sqv;
    logic [RW-1:0] r_root, n_root;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [PERIM_W-1:0] r_sum, n_sum, r_operim, n_operim;
    logic [CW-1:0] r_osize, n_osize;
    logic r_oovf, n_oovf;

    // Memories and their ports.
    logic [2*C-1:0] m_pts [MAX_POINTS];
    logic [AW-1:0] m_stk [MAX_POINTS];
    logic [2*C-1:0] r_prd, pt_wdata;
    logic [AW-1:0] r_srd, st_wdata, pt_waddr, pt_raddr, st_waddr, st_raddr;
    logic pt_we, st_we;
    logic signed [C-1:0] rd_x, rd_y;

    // Multiplier operands and loop helpers.
    logic signed [C:0] m_a, m_b;
    logic [1:0] pair;
    logic [REM_W-1:0] rem_sh, trial;
    logic [SUMW-1:0] sum_w;
    logic cmp_ready, key_first, push;

    assign rd_x = r_prd[C-1:0];
    assign rd_y = r_prd[2*C-1:C];

    // Point store and hull stack, one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            m_pts[pt_waddr] <= pt_wdata;
        end
        r_prd <= m_pts[pt_raddr];
        if (st_we) begin
            m_stk[st_waddr] <= st_wdata;
        end
        r_srd <= m_stk[st_raddr];
    end

    // Shared multiplier with operand selection by operation and phase.
    always_comb begin
        case (r_op)
            MAC_CROSS: begin
                m_a = (r_ph == 2'd0) ? r_ax : r_bx;
                m_b = (r_ph == 2'd0) ? r_by : r_ay;
            end
            MAC_DA: begin
                m_a = (r_ph == 2'd0) ? r_ax : r_ay;
                m_b = m_a;
            end
            MAC_DB: begin
                m_a = (r_ph == 2'd0) ? r_bx : r_by;
                m_b = m_a;
            end
            default: begin
                m_a = r_ax;
                m_b = r_by;
            end
        endcase
        mul = m_a * m_b;
    end

    // One square root digit per step.
    assign pair   = r_sqv[SQV_W-1 -: 2];
    assign rem_sh = {r_rem[REM_W-3:0], pair};
    assign trial  = {r_root, 2'b01};
    assign sum_w  = SUMW'(r_sum) + SUMW'(r_root);

    // Sequencer next state.
    always_comb begin
        n_state = r_state; n_ret = r_ret; n_op = r_op; n_ph = r_ph;
        n_cnt = r_cnt; n_i = r_i; n_j = r_j; n_top = r_top; n_k = r_k;
        n_ovf = r_ovf; n_close = r_close; n_ovalid = r_ovalid; n_sc = r_sc;
        n_pvx = r_pvx; n_pvy = r_pvy; n_kx = r_kx; n_ky = r_ky;
        n_wx = r_wx; n_wy = r_wy; n_tx = r_tx; n_ty = r_ty; n_sx = r_sx; n_sy = r_sy;
        n_ax = r_ax; n_ay = r_ay; n_bx = r_bx; n_by = r_by;
        n_acc = r_acc; n_da = r_da; n_sqv = r_sqv; n_root = r_root; n_rem = r_rem;
        n_sum = r_sum; n_operim = r_operim; n_osize = r_osize; n_oovf = r_oovf;
        pt_we = 1'b0; pt_waddr = '0; pt_wdata = {r_ky, r_kx}; pt_raddr = '0;
        st_we = 1'b0; st_waddr = r_top[AW-1:0]; st_wdata = r_i[AW-1:0]; st_raddr = '0;
        cmp_ready = 1'b0; key_first = 1'b0; push = 1'b0;

        // The output register empties when its transaction completes.
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_LOAD: begin
                if (i_valid) begin
                    if (r_cnt < CW'(MAX_POINTS)) begin
                        pt_we = 1'b1;
                        pt_waddr = r_cnt[AW-1:0];
                        pt_wdata = {i_py, i_px};
                        if (r_cnt == '0 || i_py < r_pvy || (i_py == r_pvy && i_px > r_pvx)) begin
                            n_pvx = i_px;
                            n_pvy = i_py;
                        end
                        n_cnt = r_cnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_is_last) begin
                        n_i = CW'(1);
                        n_state = ST_SORT_NEXT;
                    end
                end
            end
            // Insertion sort around the pivot.
            ST_SORT_NEXT: begin
                if (r_i < r_cnt) begin
                    pt_raddr = r_i[AW-1:0];
                    n_state = ST_SORT_KWAIT;
                end else begin
                    n_state = ST_SCAN_INIT;
                end
            end
            ST_SORT_KWAIT: begin
                n_kx = rd_x;
                n_ky = rd_y;
                n_j = r_i;
                n_state = ST_SORT_RD;
            end
            ST_SORT_RD: begin
                if (r_j == '0) begin
                    pt_we = 1'b1;
                    pt_waddr = '0;
                    n_i = r_i + CW'(1);
                    n_state = ST_SORT_NEXT;
                end else begin
                    pt_raddr = AW'(r_j - CW'(1));
                    n_state = ST_SORT_BWAIT;
                end
            end
            ST_SORT_BWAIT: begin
                n_wx = rd_x;
                n_wy = rd_y;
                n_ax = f_sub(r_kx, r_pvx);
                n_ay = f_sub(r_ky, r_pvy);
                n_bx = f_sub(rd_x, r_pvx);
                n_by = f_sub(rd_y, r_pvy);
                n_op = MAC_CROSS;
                n_ph = 2'd0;
                n_ret = ST_SORT_CHK;
                n_state = ST_MAC;
            end
            ST_SORT_CHK: begin
                if (r_acc != '0) begin
                    cmp_ready = 1'b1;
                    key_first = !r_acc[W-1];
                end else begin
                    n_op = MAC_DA;
                    n_ph = 2'd0;
                    n_ret = ST_SORT_DA;
                    n_state = ST_MAC;
                end
            end
            ST_SORT_DA: begin
                n_da = r_acc;
                n_op = MAC_DB;
                n_ph = 2'd0;
                n_ret = ST_SORT_DB;
                n_state = ST_MAC;
            end
            ST_SORT_DB: begin
                cmp_ready = 1'b1;
                key_first = r_da < r_acc;
            end
            // Two products, each registered, then added or subtracted.
            ST_MAC: begin
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else if (r_ph == 2'd1) begin
                    n_acc = W'(r_prod);
                    n_ph = 2'd2;
                end else begin
                    n_acc = (r_op == MAC_CROSS) ? r_acc - W'(r_prod) : r_acc + W'(r_prod);
                    n_ph = 2'd0;
                    n_state = r_ret;
                end
            end
            // Graham scan; top and second stack points stay in registers.
            ST_SCAN_INIT: begin
                st_we = 1'b1;
                st_waddr = '0;
                st_wdata = '0;
                n_top = CW'(1);
                if (r_cnt < CW'(2)) begin
                    n_state = ST_PER_INIT;
                end else begin
                    pt_raddr = '0;
                    n_state = ST_SCAN_P0;
                end
            end
            ST_SCAN_P0: begin
                n_sx = rd_x;
                n_sy = rd_y;
                pt_raddr = AW'(1);
                n_state = ST_SCAN_P1;
            end
            ST_SCAN_P1: begin
                n_tx = rd_x;
                n_ty = rd_y;
                st_we = 1'b1;
                st_waddr = AW'(1);
                st_wdata = AW'(1);
                n_top = CW'(2);
                n_i = CW'(2);
                n_state = ST_SCAN_NEXT;
            end
            ST_SCAN_NEXT: begin
                if (r_i < r_cnt) begin
                    pt_raddr = r_i[AW-1:0];
                    n_state = ST_SCAN_IWAIT;
                end else begin
                    n_state = ST_PER_INIT;
                end
            end
            ST_SCAN_IWAIT: begin
                n_kx = rd_x;
                n_ky = rd_y;
                n_state = ST_SCAN_TEST;
            end
            ST_SCAN_TEST: begin
                if (r_top >= CW'(2)) begin
                    n_ax = f_sub(r_kx, r_tx);
                    n_ay = f_sub(r_ky, r_ty);
                    n_bx = f_sub(r_tx, r_sx);
                    n_by = f_sub(r_ty, r_sy);
                    n_op = MAC_CROSS;
                    n_ph = 2'd0;
                    n_ret = ST_SCAN_CHK;
                    n_state = ST_MAC;
                end else begin
                    push = 1'b1;
                end
            end
            ST_SCAN_CHK: begin
                if (r_acc[W-1]) begin
                    push = 1'b1;
                end else begin
                    // Non-left turn: pop, and fetch the new second entry.
                    n_top = r_top - CW'(1);
                    n_tx = r_sx;
                    n_ty = r_sy;
                    if (r_top >= CW'(3)) begin
                        st_raddr = AW'(r_top - CW'(3));
                        n_state = ST_SCAN_SWAIT;
                    end else begin
                        n_state = ST_SCAN_TEST;
                    end
                end
            end
            ST_SCAN_SWAIT: begin
                pt_raddr = r_srd;
                n_state = ST_SCAN_SPT;
            end
            ST_SCAN_SPT: begin
                n_sx = rd_x;
                n_sy = rd_y;
                n_state = ST_SCAN_TEST;
            end
            // Perimeter walk: r_sx/r_sy hold the first vertex, r_tx/r_ty the previous.
            ST_PER_INIT: begin
                n_sum = '0;
                n_close = 1'b0;
                if (r_top < CW'(2)) begin
                    n_state = ST_DONE;
                end else begin
                    st_raddr = '0;
                    n_k = '0;
                    n_state = ST_PER_SRD;
                end
            end
            ST_PER_SRD: begin
                pt_raddr = r_srd;
                n_state = ST_PER_PT;
            end
            ST_PER_PT: begin
                n_tx = rd_x;
                n_ty = rd_y;
                if (r_k == '0) begin
                    n_sx = rd_x;
                    n_sy = rd_y;
                    n_k = CW'(1);
                    st_raddr = AW'(1);
                    n_state = ST_PER_SRD;
                end else begin
                    n_ax = f_sub(rd_x, r_tx);
                    n_ay = f_sub(rd_y, r_ty);
                    n_op = MAC_DA;
                    n_ph = 2'd0;
                    n_ret = ST_PER_SQ;
                    n_state = ST_MAC;
                end
            end
            ST_PER_SQ: begin
                n_sqv = SQV_W'($unsigned(r_acc)) << (2 * FRAC_BITS);
                n_root = '0;
                n_rem = '0;
                n_sc = SCW'(RW - 1);
                n_state = ST_ROOT;
            end
            ST_ROOT: begin
                n_sqv = r_sqv << 2;
                if (rem_sh >= trial) begin
                    n_rem = rem_sh - trial;
                    n_root = {r_root[RW-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_root = {r_root[RW-2:0], 1'b0};
                end
                if (r_sc == '0) begin
                    n_state = ST_PER_ADD;
                end else begin
                    n_sc = r_sc - SCW'(1);
                end
            end
            ST_PER_ADD: begin
                n_sum = (sum_w > SUMW'(PERIM_MAX)) ? PERIM_MAX : sum_w[PERIM_W-1:0];
                if (r_close) begin
                    n_state = ST_DONE;
                end else if (r_k == r_top - CW'(1)) begin
                    // Closing edge back to the first vertex.
                    n_ax = f_sub(r_sx, r_tx);
                    n_ay = f_sub(r_sy, r_ty);
                    n_close = 1'b1;
                    n_op = MAC_DA;
                    n_ph = 2'd0;
                    n_ret = ST_PER_SQ;
                    n_state = ST_MAC;
                end else begin
                    n_k = r_k + CW'(1);
                    st_raddr = AW'(r_k + CW'(1));
                    n_state = ST_PER_SRD;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_operim = r_sum;
                    n_osize = r_top;
                    n_oovf = r_ovf;
                    n_ovalid = 1'b1;
                    n_cnt = '0;
                    n_ovf = 1'b0;
                    n_top = '0;
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        // Sort step outcome: shift the neighbor up, or drop the key in place.
        if (cmp_ready) begin
            pt_we = 1'b1;
            pt_waddr = r_j[AW-1:0];
            if (key_first) begin
                pt_wdata = {r_wy, r_wx};
                n_j = r_j - CW'(1);
                n_state = ST_SORT_RD;
            end else begin
                n_i = r_i + CW'(1);
                n_state = ST_SORT_NEXT;
            end
        end

        // Push the current point onto the hull stack.
        if (push) begin
            st_we = 1'b1;
            n_sx = r_tx;
            n_sy = r_ty;
            n_tx = r_kx;
            n_ty = r_ky;
            n_top = r_top + CW'(1);
            n_i = r_i + CW'(1);
            n_state = ST_SCAN_NEXT;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_ret <= ST_LOAD;
            r_op <= MAC_CROSS;
            r_ph <= 2'd0;
            r_cnt <= '0;
            r_i <= '0;
            r_j <= '0;
            r_top <= '0;
            r_k <= '0;
            r_ovf <= 1'b0;
            r_close <= 1'b0;
            r_ovalid <= 1'b0;
            r_sc <= '0;
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
            r_op <= n_op;
            r_ph <= n_ph;
            r_cnt <= n_cnt;
            r_i <= n_i;
            r_j <= n_j;
            r_top <= n_top;
            r_k <= n_k;
            r_ovf <= n_ovf;
            r_close <= n_close;
            r_ovalid <= n_ovalid;
            r_sc <= n_sc;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_pvx <= n_pvx; r_pvy <= n_pvy;
        r_kx <= n_kx; r_ky <= n_ky; r_wx <= n_wx; r_wy <= n_wy;
        r_tx <= n_tx; r_ty <= n_ty; r_sx <= n_sx; r_sy <= n_sy;
        r_ax <= n_ax; r_ay <= n_ay; r_bx <= n_bx; r_by <= n_by;
        r_prod <= mul;
        r_acc <= n_acc; r_da <= n_da;
        r_sqv <= n_sqv; r_root <= n_root; r_rem <= n_rem;
        r_sum <= n_sum;
        r_operim <= n_operim; r_osize <= n_osize; r_oovf <= n_oovf;
    end

    assign o_stall      = (r_state != ST_LOAD);
    assign o_valid      = r_ovalid;
    assign o_perimeter  = r_operim;
    assign o_hull_size  = r_osize;
    assign o_overflowed = r_oovf;

    // The hull stack never holds more entries than points loaded.
    a_top_le_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= r_cnt) else $error("hull stack deeper than point count");

    // The point count stays within capacity.
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_POINTS)) else $error("point count beyond capacity");

    // A new result appears only out of the final state.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid)) |-> $past(r_state == ST_DONE))
        else $error("result raised outside the final state");

endmodule
